// ----- hdl/r2rgb_pkg.sv -----
// shared types, constants and colour helper for the raster to rgb565 converter
package r2rgb_pkg;

    // square display geometry
    localparam int DISPLAY_SIDE = 240;
    localparam int POS_W        = $clog2(DISPLAY_SIDE);

    localparam int COORD_W = 12;
    localparam int INDEX_W = 16;
    localparam int COLOR_W = 16;
    localparam int CFG_W   = 12;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [2:0] t_fmt;
    localparam t_fmt FMT_RGBA32 = 3'd0;
    localparam t_fmt FMT_RGB24  = 3'd1;
    localparam t_fmt FMT_MONO   = 3'd2;
    localparam t_fmt FMT_RGB565 = 3'd3;
    localparam t_fmt FMT_PLACED = 3'd4;

    typedef logic [1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_PIXEL_FORMAT  = 2'd0;
    localparam t_cfg_addr CFG_SOURCE_WIDTH  = 2'd1;
    localparam t_cfg_addr CFG_SOURCE_HEIGHT = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic [INDEX_W-1:0] pixel_index;
        logic               frame_done;
    } t_out_word;

    // one pixel handed from front to back
    typedef struct packed {
        logic               is_placed;
        logic [COLOR_W-1:0] color;
        logic [INDEX_W-1:0] index;
        logic [POS_W-1:0]   dx;
        logic [POS_W-1:0]   dy;
        logic               done;
    } t_job;

    function automatic logic [COLOR_W-1:0] to565(input logic [23:0] rgb);
        return {rgb[23:19], rgb[15:10], rgb[7:3]};
    endfunction

endpackage

// ----- hdl/r2rgb_front.sv -----
// front end: config registers, byte gathering, position counters, pixel jobs
module r2rgb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  r2rgb_pkg::t_cfg_addr i_cfg_addr,
    input  logic [r2rgb_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                i_push,
    input  r2rgb_pkg::t_in_word i_in_word,
    output logic                o_full,
    input  logic                i_q_full,
    output logic                o_job_valid,
    output r2rgb_pkg::t_job     o_job
);

    localparam int CW = r2rgb_pkg::COORD_W;
    localparam logic [CW-1:0] SIDE      = CW'(r2rgb_pkg::DISPLAY_SIDE);
    localparam logic [CW-1:0] SIDE_LAST = CW'(r2rgb_pkg::DISPLAY_SIDE - 1);

    r2rgb_pkg::t_fmt r_fmt;
    logic [CW-1:0]   r_width, r_height;

    logic [23:0]     r_gather, n_gather;
    logic [1:0]      r_phase, n_phase;
    logic [CW-1:0]   r_col, n_col, r_row, n_row;
    logic [r2rgb_pkg::INDEX_W-1:0] r_count, n_count;
    logic            r_busy, n_busy;
    logic [2:0]      r_bit, n_bit;
    logic [7:0]      r_byte, n_byte;

    logic            accept, go;

    // placement geometry from the config registers
    logic [CW-1:0]   wl, hl, sox, soy, dox, doy, cw, ch;
    logic [CW:0]     x_hi, y_hi;

    always_comb begin
        wl   = (r_width == '0) ? CW'(1) : r_width;
        hl   = (r_height == '0) ? CW'(1) : r_height;
        sox  = (r_width > SIDE) ? (r_width - SIDE) >> 1 : '0;
        soy  = (r_height > SIDE) ? (r_height - SIDE) >> 1 : '0;
        dox  = (r_width < SIDE) ? (SIDE - r_width) >> 1 : '0;
        doy  = (r_height < SIDE) ? (SIDE - r_height) >> 1 : '0;
        cw   = (r_width < SIDE) ? r_width : SIDE;
        ch   = (r_height < SIDE) ? r_height : SIDE;
        x_hi = {1'b0, sox} + {1'b0, cw};
        y_hi = {1'b0, soy} + {1'b0, ch};
    end

    assign o_full = r_busy || i_q_full;
    assign accept = i_push && !o_full;
    assign go     = r_busy ? !i_q_full : accept;

    always_comb begin
        logic [23:0]  g;
        logic [1:0]   ph;
        logic [CW-1:0] col, row;
        logic [r2rgb_pkg::INDEX_W-1:0] cnt;
        logic [2:0]   need;
        logic         fire_fixed, fire_placed, pix_bit, in_region;
        logic [r2rgb_pkg::COLOR_W-1:0] color;
        logic [7:0]   d_byte;

        d_byte      = i_in_word.data_byte;
        g           = r_gather;
        ph          = r_phase;
        col         = r_col;
        row         = r_row;
        cnt         = r_count;
        need        = 3'd0;
        fire_fixed  = 1'b0;
        fire_placed = 1'b0;
        pix_bit     = 1'b0;
        in_region   = 1'b0;
        color       = '0;
        n_busy      = r_busy;
        n_bit       = r_bit;
        n_byte      = r_byte;
        o_job_valid = 1'b0;
        o_job       = '0;

        if (go) begin
            if (accept && i_in_word.frame_start) begin
                g   = '0;
                ph  = '0;
                col = '0;
                row = '0;
                cnt = '0;
            end

            if (r_fmt == r2rgb_pkg::FMT_MONO) begin
                // msb first, one bit per cycle while the job queue is not full
                pix_bit    = r_busy ? r_byte[r_bit] : d_byte[7];
                color      = pix_bit ? 16'hFFFF : 16'h0000;
                fire_fixed = 1'b1;
                if (r_busy) begin
                    if (r_bit == 3'd0) begin
                        n_busy = 1'b0;
                    end else begin
                        n_bit = r_bit - 3'd1;
                    end
                end else begin
                    n_busy = 1'b1;
                    n_bit  = 3'd6;
                    n_byte = d_byte;
                end
            end else begin
                unique case (r_fmt)
                    r2rgb_pkg::FMT_RGBA32,
                    r2rgb_pkg::FMT_PLACED: need = 3'd4;
                    r2rgb_pkg::FMT_RGB24:  need = 3'd3;
                    r2rgb_pkg::FMT_RGB565: need = 3'd2;
                    default:               need = 3'd0;
                endcase
                if (need != 3'd0) begin
                    // alpha byte of a four-byte pixel is not gathered
                    if (ph != 2'd3) begin
                        g = {g[15:0], d_byte};
                    end
                    if ({1'b0, ph} + 3'd1 < need) begin
                        ph = ph + 2'd1;
                    end else begin
                        ph = '0;
                        if (r_fmt == r2rgb_pkg::FMT_RGB565) begin
                            color      = g[15:0];
                            fire_fixed = 1'b1;
                        end else if (r_fmt == r2rgb_pkg::FMT_PLACED) begin
                            color       = r2rgb_pkg::to565(g);
                            fire_placed = 1'b1;
                        end else begin
                            color      = r2rgb_pkg::to565(g);
                            fire_fixed = 1'b1;
                        end
                    end
                end
            end

            if (fire_fixed && row < SIDE) begin
                o_job_valid     = 1'b1;
                o_job.is_placed = 1'b0;
                o_job.color     = color;
                o_job.index     = cnt;
                o_job.done      = (row == SIDE_LAST) && (col == SIDE_LAST);
                cnt             = cnt + 1'b1;
                if (col >= SIDE_LAST) begin
                    col = '0;
                    row = row + 1'b1;
                end else begin
                    col = col + 1'b1;
                end
            end

            if (fire_placed && row < hl) begin
                in_region = (col >= sox) && ({1'b0, col} < x_hi) &&
                            (row >= soy) && ({1'b0, row} < y_hi);
                o_job_valid     = in_region;
                o_job.is_placed = 1'b1;
                o_job.color     = color;
                o_job.dx        = r2rgb_pkg::POS_W'(col - sox + dox);
                o_job.dy        = r2rgb_pkg::POS_W'(row - soy + doy);
                o_job.done      = ({1'b0, col} == x_hi - 1'b1) &&
                                  ({1'b0, row} == y_hi - 1'b1);
                if (col >= wl - 1'b1) begin
                    col = '0;
                    row = row + 1'b1;
                end else begin
                    col = col + 1'b1;
                end
            end
        end

        n_gather = g;
        n_phase  = ph;
        n_col    = col;
        n_row    = row;
        n_count  = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= r2rgb_pkg::FMT_RGBA32;
            r_width  <= SIDE;
            r_height <= SIDE;
            r_gather <= '0;
            r_phase  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_count  <= '0;
            r_busy   <= 1'b0;
            r_bit    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    r2rgb_pkg::CFG_PIXEL_FORMAT:  r_fmt    <= i_cfg_data[2:0];
                    r2rgb_pkg::CFG_SOURCE_WIDTH:  r_width  <= i_cfg_data;
                    r2rgb_pkg::CFG_SOURCE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_gather <= n_gather;
            r_phase  <= n_phase;
            r_col    <= n_col;
            r_row    <= n_row;
            r_count  <= n_count;
            r_busy   <= n_busy;
            r_bit    <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

// ----- hdl/r2rgb_queue.sv -----
// short job queue between front and back ends
module r2rgb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  r2rgb_pkg::t_job i_wr_job,
    output logic            o_full,
    input  logic            i_rd_en,
    output r2rgb_pkg::t_job o_rd_job,
    output logic            o_empty
);

    localparam int PW = r2rgb_pkg::QPTR_W;

    r2rgb_pkg::t_job r_slot [r2rgb_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PW:0]     r_count;
    logic            wr, rd;

    assign o_full   = (r_count == (PW+1)'(r2rgb_pkg::QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign wr       = i_wr_en && !o_full;
    assign rd       = i_rd_en && !o_empty;
    assign o_rd_job = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wr_ptr] <= i_wr_job;
        end
    end

endmodule

// ----- hdl/r2rgb_back.sv -----
// back end: display index for placed pixels and the output word register
module r2rgb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_empty,
    input  r2rgb_pkg::t_job      i_job,
    output logic                 o_job_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output r2rgb_pkg::t_out_word o_out_word
);

    localparam int IW = r2rgb_pkg::INDEX_W;

    logic                 r_valid, n_valid;
    r2rgb_pkg::t_out_word r_word, n_word;
    logic [IW-1:0]        placed_index;

    assign o_job_pop    = !i_job_empty && (!r_valid || i_pop);
    assign placed_index = IW'(i_job.dy) * IW'(r2rgb_pkg::DISPLAY_SIDE) + IW'(i_job.dx);

    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        if (o_job_pop) begin
            n_valid            = 1'b1;
            n_word.pixel_color = i_job.color;
            n_word.pixel_index = i_job.is_placed ? placed_index : i_job.index;
            n_word.frame_done  = i_job.done;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_empty    = !r_valid;
    assign o_out_word = r_word;

endmodule

// ----- hdl/raster_to_rgb565_converter.sv -----
// top level of the raster to rgb565 converter: front end, job queue, back end
// path: a completed pixel passes the job queue and the output word register in order
// throughput: one byte per cycle in byte modes, set by the gather step, unless q_full
// mono: full stays high until a byte's last bit is out; the next byte waits for it
// reset: synchronous, active low; counters and queues clear, config returns to
// rgba32 at 240 x 240; there is no clearing pass
module raster_to_rgb565_converter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  r2rgb_pkg::t_cfg_addr i_cfg_addr,
    input  logic [r2rgb_pkg::CFG_W-1:0] i_cfg_data,
    // byte words in
    input  logic                 push,
    output logic                 full,
    input  r2rgb_pkg::t_in_word  i_in_word,
    // pixel words out
    output logic                 empty,
    input  logic                 pop,
    output r2rgb_pkg::t_out_word o_out_word
);

    // front to queue
    logic            job_valid;
    r2rgb_pkg::t_job job_in;
    logic            q_full;

    // queue to back
    logic            q_empty;
    logic            q_pop;
    r2rgb_pkg::t_job job_out;

    // front end takes bytes, tracks position and decides which pixels exist
    r2rgb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_in_word   (i_in_word),
        .o_full      (full),
        .i_q_full    (q_full),
        .o_job_valid (job_valid),
        .o_job       (job_in)
    );

    // decouples the front end from output back-pressure
    r2rgb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (job_valid),
        .i_wr_job (job_in),
        .o_full   (q_full),
        .i_rd_en  (q_pop),
        .o_rd_job (job_out),
        .o_empty  (q_empty)
    );

    // back end forms the display index and holds the outgoing word
    r2rgb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (job_out),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_word  (o_out_word)
    );

endmodule
